>>> hw/rtl/bbo_pkg.sv
package bbo_pkg;

  // Table geometry and field widths
  localparam int NUM_VENUES  = 8;
  localparam int NUM_SYMBOLS = 256;
  localparam int PRICE_BITS  = 32;
  localparam int QTY_BITS    = 32;
  localparam int TOTAL_BITS  = 35;
  localparam int VENUE_BITS  = $clog2(NUM_VENUES);
  localparam int SYMBOL_BITS = $clog2(NUM_SYMBOLS);
  localparam int TABLE_DEPTH = NUM_SYMBOLS * NUM_VENUES;
  localparam int TABLE_BITS  = $clog2(TABLE_DEPTH);
  localparam int ENABLE_BITS = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_VENUE_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NOTIFY_ENABLE = 1'b1;

  // One venue's top of book for one symbol
  typedef struct packed {
    logic                  bid_flag;
    logic [PRICE_BITS-1:0] bid_px;
    logic [QTY_BITS-1:0]   bid_qty;
    logic                  ask_flag;
    logic [PRICE_BITS-1:0] ask_px;
    logic [QTY_BITS-1:0]   ask_qty;
  } venue_entry_t;

  // One side of a consolidated quote, as cached per symbol
  typedef struct packed {
    logic                  valid;
    logic [PRICE_BITS-1:0] price;
    logic [TOTAL_BITS-1:0] total;
  } side_t;

  typedef struct packed {
    side_t bid;
    side_t ask;
  } quote_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_UPDATE
  } state_t;

endpackage

>>> hw/rtl/best_bid_offer_consolidator_top.sv
// Each accepted request passes through the SCAN, LAST and UPDATE states, and
// a new request is taken only in IDLE, once the previous one is through; the scan
// reads one venue entry a cycle from the venue table over all 8 venues.
// An update stalls only if the previous result is still waiting at the output.
// Reset: synchronous; afterwards a clearing pass zeroes the venue table and the
// quote cache, with in_ready low (configuration writes still taken).
module best_bid_offer_consolidator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [bbo_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [bbo_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // update requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bbo_pkg::VENUE_BITS-1:0]       venue,
  input  logic [bbo_pkg::SYMBOL_BITS-1:0]      symbol_index,
  input  logic                                 bid_present,
  input  logic [bbo_pkg::PRICE_BITS-1:0]       bid_price,
  input  logic [bbo_pkg::QTY_BITS-1:0]         bid_size,
  input  logic                                 ask_present,
  input  logic [bbo_pkg::PRICE_BITS-1:0]       ask_price,
  input  logic [bbo_pkg::QTY_BITS-1:0]         ask_size,
  // consolidated quote results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bbo_pkg::SYMBOL_BITS-1:0]      out_symbol,
  output logic                                 best_bid_valid,
  output logic [bbo_pkg::PRICE_BITS-1:0]       best_bid_price,
  output logic [bbo_pkg::TOTAL_BITS-1:0]       best_bid_total,
  output logic [bbo_pkg::VENUE_BITS-1:0]       best_bid_src,
  output logic                                 best_ask_valid,
  output logic [bbo_pkg::PRICE_BITS-1:0]       best_ask_price,
  output logic [bbo_pkg::TOTAL_BITS-1:0]       best_ask_total,
  output logic [bbo_pkg::VENUE_BITS-1:0]       best_ask_src
);

  bbo_pkg::state_t state, state_next;

  logic [bbo_pkg::ENABLE_BITS-1:0] venue_enable;
  logic                            notify_enable;

  logic [bbo_pkg::TABLE_BITS-1:0]  clr_cnt;
  logic                            clr_done;
  logic [bbo_pkg::SYMBOL_BITS-1:0] sym;
  logic [bbo_pkg::VENUE_BITS-1:0]  scan_k;
  logic                            scan_last;
  logic                            proc_valid;
  logic [bbo_pkg::VENUE_BITS-1:0]  proc_k;
  logic                            accept;
  logic                            upd_go;
  logic                            changed;

  // venue table and quote cache
  bbo_pkg::venue_entry_t ven_mem [bbo_pkg::TABLE_DEPTH];
  bbo_pkg::venue_entry_t ven_rd;
  bbo_pkg::venue_entry_t ven_wdata;
  logic [bbo_pkg::TABLE_BITS-1:0] ven_waddr;
  logic                           ven_we;
  bbo_pkg::quote_t cache_mem [bbo_pkg::NUM_SYMBOLS];
  bbo_pkg::quote_t cache_rd;
  bbo_pkg::quote_t cache_wdata;
  logic [bbo_pkg::SYMBOL_BITS-1:0] cache_waddr;
  logic                            cache_we;

  // running best per side
  logic                            bid_v, bid_v_next, ask_v, ask_v_next;
  logic [bbo_pkg::PRICE_BITS-1:0]  bid_px, bid_px_next, ask_px, ask_px_next;
  logic [bbo_pkg::TOTAL_BITS-1:0]  bid_tot, bid_tot_next, ask_tot, ask_tot_next;
  logic [bbo_pkg::VENUE_BITS-1:0]  bid_ven, bid_ven_next, ask_ven, ask_ven_next;
  bbo_pkg::quote_t                 new_quote;

  assign accept    = in_valid && in_ready;
  assign clr_done  = (clr_cnt == bbo_pkg::TABLE_BITS'(bbo_pkg::TABLE_DEPTH - 1));
  assign scan_last = (scan_k == bbo_pkg::VENUE_BITS'(bbo_pkg::NUM_VENUES - 1));
  assign upd_go    = !out_valid || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      venue_enable  <= '0;
      notify_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbo_pkg::CFG_VENUE_ENABLE:  venue_enable  <= cfg_data;
        bbo_pkg::CFG_NOTIFY_ENABLE: notify_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbo_pkg::ST_CLEAR:  if (clr_done) state_next = bbo_pkg::ST_IDLE;
      bbo_pkg::ST_IDLE:   if (in_valid) state_next = bbo_pkg::ST_SCAN;
      bbo_pkg::ST_SCAN:   if (scan_last) state_next = bbo_pkg::ST_LAST;
      bbo_pkg::ST_LAST:   state_next = bbo_pkg::ST_UPDATE;
      bbo_pkg::ST_UPDATE: if (upd_go) state_next = bbo_pkg::ST_IDLE;
      default:            state_next = bbo_pkg::ST_CLEAR;
    endcase
  end

  // Sequencer: outputs and memory write ports
  always_comb begin
    in_ready    = 1'b0;
    ven_we      = 1'b0;
    ven_waddr   = {symbol_index, venue};
    ven_wdata   = '{bid_flag: bid_present, bid_px: bid_price, bid_qty: bid_size,
                    ask_flag: ask_present, ask_px: ask_price, ask_qty: ask_size};
    cache_we    = 1'b0;
    cache_waddr = sym;
    cache_wdata = new_quote;
    unique case (state)
      bbo_pkg::ST_CLEAR: begin
        ven_we      = 1'b1;
        ven_waddr   = clr_cnt;
        ven_wdata   = '0;
        cache_we    = 1'b1;
        cache_waddr = clr_cnt[bbo_pkg::SYMBOL_BITS-1:0];
        cache_wdata = '0;
      end
      bbo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ven_we   = in_valid;
      end
      bbo_pkg::ST_UPDATE: cache_we = upd_go;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bbo_pkg::ST_CLEAR;
      clr_cnt    <= '0;
      scan_k     <= '0;
      proc_valid <= 1'b0;
    end else begin
      state      <= state_next;
      proc_valid <= (state == bbo_pkg::ST_SCAN);
      if (state == bbo_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (accept) begin
        scan_k <= '0;
      end else if (state == bbo_pkg::ST_SCAN) begin
        scan_k <= scan_k + 1'b1;
      end
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (ven_we) ven_mem[ven_waddr] <= ven_wdata;
    ven_rd <= ven_mem[{sym, scan_k}];
  end

  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    cache_rd <= cache_mem[sym];
  end

  // Compare unit: fold one venue entry into the running best
  always_comb begin
    bid_v_next   = bid_v;
    bid_px_next  = bid_px;
    bid_tot_next = bid_tot;
    bid_ven_next = bid_ven;
    ask_v_next   = ask_v;
    ask_px_next  = ask_px;
    ask_tot_next = ask_tot;
    ask_ven_next = ask_ven;
    if (proc_valid && venue_enable[proc_k]) begin
      if (ven_rd.bid_flag) begin
        priority if (!bid_v || ven_rd.bid_px > bid_px) begin
          bid_v_next   = 1'b1;
          bid_px_next  = ven_rd.bid_px;
          bid_tot_next = bbo_pkg::TOTAL_BITS'(ven_rd.bid_qty);
          bid_ven_next = proc_k;
        end else if (ven_rd.bid_px == bid_px) begin
          bid_tot_next = bid_tot + bbo_pkg::TOTAL_BITS'(ven_rd.bid_qty);
        end
      end
      if (ven_rd.ask_flag) begin
        priority if (!ask_v || ven_rd.ask_px < ask_px) begin
          ask_v_next   = 1'b1;
          ask_px_next  = ven_rd.ask_px;
          ask_tot_next = bbo_pkg::TOTAL_BITS'(ven_rd.ask_qty);
          ask_ven_next = proc_k;
        end else if (ven_rd.ask_px == ask_px) begin
          ask_tot_next = ask_tot + bbo_pkg::TOTAL_BITS'(ven_rd.ask_qty);
        end
      end
    end
  end

  // Hold the symbol, reset the running best on accept, advance on each entry
  always_ff @(posedge clk) begin
    proc_k <= scan_k;
    if (accept) begin
      sym     <= symbol_index;
      bid_v   <= 1'b0;
      bid_px  <= '0;
      bid_tot <= '0;
      bid_ven <= '0;
      ask_v   <= 1'b0;
      ask_px  <= '0;
      ask_tot <= '0;
      ask_ven <= '0;
    end else begin
      bid_v   <= bid_v_next;
      bid_px  <= bid_px_next;
      bid_tot <= bid_tot_next;
      bid_ven <= bid_ven_next;
      ask_v   <= ask_v_next;
      ask_px  <= ask_px_next;
      ask_tot <= ask_tot_next;
      ask_ven <= ask_ven_next;
    end
  end

  assign new_quote = '{bid: '{valid: bid_v, price: bid_px, total: bid_tot},
                       ask: '{valid: ask_v, price: ask_px, total: ask_tot}};
  assign changed   = (new_quote != cache_rd);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bbo_pkg::ST_UPDATE && upd_go && notify_enable && changed) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bbo_pkg::ST_UPDATE && upd_go) begin
      out_symbol     <= sym;
      best_bid_valid <= bid_v;
      best_bid_price <= bid_px;
      best_bid_total <= bid_tot;
      best_bid_src   <= bid_ven;
      best_ask_valid <= ask_v;
      best_ask_price <= ask_px;
      best_ask_total <= ask_tot;
      best_ask_src   <= ask_ven;
    end
  end

  // Checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == bbo_pkg::ST_SCAN) && (scan_k == '0) && !in_ready)
    else $error("accepted request did not start a scan from venue zero");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == bbo_pkg::ST_CLEAR) |-> !out_valid)
    else $error("result raised during clearing pass");

  a_proc_in_scan: assert property (@(posedge clk) disable iff (rst)
    proc_valid |-> (state == bbo_pkg::ST_SCAN || state == bbo_pkg::ST_LAST))
    else $error("venue entry folded outside the scan");

  a_absent_bid_zero: assert property (@(posedge clk) disable iff (rst)
    (state == bbo_pkg::ST_UPDATE && !bid_v) |-> (bid_px == '0 && bid_tot == '0))
    else $error("absent bid side carries a price or total");

  a_absent_ask_zero: assert property (@(posedge clk) disable iff (rst)
    (state == bbo_pkg::ST_UPDATE && !ask_v) |-> (ask_px == '0 && ask_tot == '0))
    else $error("absent ask side carries a price or total");

endmodule
